// ===== design/uep0_pkg.sv =====
// Package for the USB endpoint zero control handler.
// Holds codes, the decoded request and result records, and the phase encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uep0_pkg;

  localparam int LenW = 16;

  localparam logic [1:0] CMD_SETUP     = 2'd0;
  localparam logic [1:0] CMD_OUT       = 2'd1;
  localparam logic [1:0] CMD_IN        = 2'd2;
  localparam logic [1:0] CMD_BUS_RESET = 2'd3;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_ZLP   = 2'd2;
  localparam logic [1:0] ACT_STALL = 2'd3;

  localparam logic [2:0] SRC_STATUS      = 3'd0;
  localparam logic [2:0] SRC_CONFIG_BYTE = 3'd1;
  localparam logic [2:0] SRC_ZERO        = 3'd2;
  localparam logic [2:0] SRC_HALTED      = 3'd3;
  localparam logic [2:0] SRC_DEVICE      = 3'd4;
  localparam logic [2:0] SRC_CONFIG      = 3'd5;
  localparam logic [2:0] SRC_STRING      = 3'd6;
  localparam logic [2:0] SRC_COMPAT      = 3'd7;

  localparam logic [2:0] CFG_DEVICE_DESC_LEN    = 3'd0;
  localparam logic [2:0] CFG_CONFIG_DESC_LEN    = 3'd1;
  localparam logic [2:0] CFG_MAX_PACKET_SIZE0   = 3'd2;
  localparam logic [2:0] CFG_COMPAT_ID_LEN      = 3'd3;
  localparam logic [2:0] CFG_COMPAT_VENDOR_CODE = 3'd4;

  localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
  localparam logic [7:0] REQ_SYNCH_FRAME    = 8'd12;

  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;

  localparam logic [6:0] RT_STD_DEVICE    = 7'h00;
  localparam logic [6:0] RT_STD_IFACE     = 7'h01;
  localparam logic [6:0] RT_STD_EP        = 7'h02;
  localparam logic [6:0] RT_VENDOR_DEVICE = 7'h40;

  localparam logic [15:0] COMPAT_INDEX       = 16'h0004;
  localparam logic [7:0]  FEAT_REMOTE_WAKEUP = 8'h01;

  localparam logic [6:0] MPS_MIN = 7'd8;
  localparam logic [6:0] MPS_MAX = 7'd64;

  localparam logic [1:0] MODE_DEFAULT  = 2'd0;
  localparam logic [1:0] MODE_SELECTED = 2'd1;
  localparam logic [1:0] MODE_ACTIVE   = 2'd2;

  localparam logic [2:0] PHC_SETUP    = 3'd0;
  localparam logic [2:0] PHC_TX       = 3'd1;
  localparam logic [2:0] PHC_TX0      = 3'd2;
  localparam logic [2:0] PHC_STS      = 3'd3;
  localparam logic [2:0] PHC_RX       = 3'd4;
  localparam logic [2:0] PHC_SEND_STS = 3'd5;
  localparam logic [2:0] PHC_ERROR    = 3'd6;

  typedef enum logic [6:0] {
    PH_SETUP    = 7'b0000001,
    PH_TX       = 7'b0000010,
    PH_TX0      = 7'b0000100,
    PH_STS      = 7'b0001000,
    PH_RX       = 7'b0010000,
    PH_SEND_STS = 7'b0100000,
    PH_ERROR    = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    K_SETUP     = 3'd0,
    K_ERROR     = 3'd1,
    K_OUT       = 3'd2,
    K_IN        = 3'd3,
    K_BUS_RESET = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_CLR_WAKE   = 3'd1,
    OP_SET_WAKE   = 3'd2,
    OP_SET_ADDR   = 3'd3,
    OP_SET_CFG    = 3'd4,
    OP_EP_STATUS  = 3'd5,
    OP_EP_FEATURE = 3'd6
  } op_t;

  typedef struct packed {
    kind_t            kind;
    op_t              op;
    logic [1:0]       action;
    phase_t           phase;
    logic [2:0]       src;
    logic [6:0]       chunk;
    logic [LenW-1:0]  tl;
    logic [LenW-1:0]  rl;
    logic [7:0]       val;
    logic [3:0]       ep_num;
    logic             ep_in;
    logic             ep_ok;
    logic             ep_set;
    logic             ep_apply;
  } dec_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] src;
    logic [6:0] chunk;
    logic       aw;
    logic [6:0] addr;
    logic [2:0] phase;
    logic [1:0] mode;
    logic       cev;
    logic [7:0] cfg;
    logic       wake;
    logic       rst;
  } res_t;

  typedef struct packed {
    logic            start;
    logic [LenW-1:0] value;
  } rem_req_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } rem_sts_t;

  function automatic logic [2:0] phase_code(input phase_t p);
    logic [2:0] c;
    case (p)
      PH_SETUP:    c = PHC_SETUP;
      PH_TX:       c = PHC_TX;
      PH_TX0:      c = PHC_TX0;
      PH_STS:      c = PHC_STS;
      PH_RX:       c = PHC_RX;
      PH_SEND_STS: c = PHC_SEND_STS;
      PH_ERROR:    c = PHC_ERROR;
      default:     c = PHC_SETUP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/usb_ep0_control_handler_core.sv =====
// Top level of the USB endpoint zero control handler.
// Instantiates uep0_front, uep0_fifo, uep0_back and uep0_rem; uses uep0_pkg.
//
// Channel   Direction  Handshake               Payload
// in_       event in   in_push / in_full       command, setup fields, string length
// out_      result     out_pop / out_empty     action, chunk, address, phase, state
// cfg_      registers  cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One event is taken per cycle while in_full is low; its result then goes to the result queue.
// An IN completion in the data phase waits until the remainder unit has
// finished for the preceding setup request; writing max_packet_size0 restarts it.
// Reset is synchronous; the result queue holds two entries, the internal queue two.
// A stalled result side fills both queues and then raises in_full; cfg_ready stays high.
`timescale 1ns / 1ps
`default_nettype none

module usb_ep0_control_handler_core #(
  parameter int NUM_ENDPOINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic        in_setup_ok,
  input  logic [7:0]  in_request_type,
  input  logic [7:0]  in_request_code,
  input  logic [15:0] in_value_word,
  input  logic [15:0] in_index_word,
  input  logic [15:0] in_length_word,
  input  logic [7:0]  in_string_len,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_action,
  output logic [2:0]  out_data_source,
  output logic [6:0]  out_chunk_len,
  output logic        out_address_write,
  output logic [6:0]  out_device_address,
  output logic [2:0]  out_ep0_phase,
  output logic [1:0]  out_device_state,
  output logic        out_config_event,
  output logic [7:0]  out_configuration,
  output logic        out_remote_wakeup,
  output logic        out_reset_event
);

  import uep0_pkg::*;

  localparam int DecW = $bits(dec_t);
  localparam int ResW = $bits(res_t);

  dec_t     dec_in, dec_head;
  res_t     res_in, res_head;
  rem_req_t rem_req;
  rem_sts_t rem_sts;
  logic [6:0] mps;
  logic     mps_wr;
  logic     dq_empty, dq_pop;
  logic     rq_full, rq_push;

  assign cfg_ready = 1'b1;

  uep0_front #(
    .NUM_ENDPOINTS(NUM_ENDPOINTS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_command      (in_command),
    .in_setup_ok     (in_setup_ok),
    .in_request_type (in_request_type),
    .in_request_code (in_request_code),
    .in_value_word   (in_value_word),
    .in_index_word   (in_index_word),
    .in_length_word  (in_length_word),
    .in_string_len   (in_string_len),
    .dec             (dec_in),
    .mps             (mps),
    .mps_wr          (mps_wr)
  );

  uep0_fifo #(
    .WIDTH(DecW),
    .DEPTH(2)
  ) u_dec_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (dec_in),
    .full  (in_full),
    .pop   (dq_pop),
    .rdata (dec_head),
    .empty (dq_empty)
  );

  uep0_back #(
    .NUM_ENDPOINTS(NUM_ENDPOINTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec_head),
    .dec_valid (!dq_empty),
    .dec_pop   (dq_pop),
    .res_full  (rq_full),
    .res_push  (rq_push),
    .res       (res_in),
    .rem_req   (rem_req),
    .rem_sts   (rem_sts)
  );

  uep0_rem u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (rem_req),
    .restart (mps_wr),
    .divisor (mps),
    .sts     (rem_sts)
  );

  uep0_fifo #(
    .WIDTH(ResW),
    .DEPTH(2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (res_in),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_action         = res_head.action;
  assign out_data_source    = res_head.src;
  assign out_chunk_len      = res_head.chunk;
  assign out_address_write  = res_head.aw;
  assign out_device_address = res_head.addr;
  assign out_ep0_phase      = res_head.phase;
  assign out_device_state   = res_head.mode;
  assign out_config_event   = res_head.cev;
  assign out_configuration  = res_head.cfg;
  assign out_remote_wakeup  = res_head.wake;
  assign out_reset_event    = res_head.rst;

endmodule

`default_nettype wire

// ===== design/uep0_fifo.sv =====
// Small register queue used between the decoder and the executer and on the result side.
// Depends on nothing; DEPTH must be a power of two of at least two.
`timescale 1ns / 1ps
`default_nettype none

module uep0_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== design/uep0_front.sv =====
// Front end: configuration registers and request decoder.
// Classifies each event into a uep0_pkg::dec_t record; uses uep0_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uep0_front #(
  parameter int NUM_ENDPOINTS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic [1:0]      in_command,
  input  logic            in_setup_ok,
  input  logic [7:0]      in_request_type,
  input  logic [7:0]      in_request_code,
  input  logic [15:0]     in_value_word,
  input  logic [15:0]     in_index_word,
  input  logic [15:0]     in_length_word,
  input  logic [7:0]      in_string_len,
  output uep0_pkg::dec_t  dec,
  output logic [6:0]      mps,
  output logic            mps_wr
);

  import uep0_pkg::*;

  logic [7:0]      dev_len_r;
  logic [15:0]     cfg_len_r;
  logic [6:0]      mps_r;
  logic [7:0]      compat_len_r;
  logic [7:0]      vendor_r;

  logic [6:0]      key;
  logic            ok_req;
  op_t             op;
  logic [2:0]      src;
  logic [LenW-1:0] tl;
  logic [LenW-1:0] desc_len;
  logic [2:0]      desc_src;
  logic            ep_ok;
  logic [LenW-1:0] min_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_len_r    <= 8'd18;
      cfg_len_r    <= 16'd32;
      mps_r        <= 7'd64;
      compat_len_r <= 8'd40;
      vendor_r     <= 8'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEVICE_DESC_LEN:    dev_len_r    <= cfg_data[7:0];
        CFG_CONFIG_DESC_LEN:    cfg_len_r    <= cfg_data;
        CFG_MAX_PACKET_SIZE0:   mps_r        <= cfg_data[6:0];
        CFG_COMPAT_ID_LEN:      compat_len_r <= cfg_data[7:0];
        CFG_COMPAT_VENDOR_CODE: vendor_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign mps_wr = cfg_valid && (cfg_index == CFG_MAX_PACKET_SIZE0);
  assign mps    = (mps_r < MPS_MIN) ? MPS_MIN : ((mps_r > MPS_MAX) ? MPS_MAX : mps_r);
  assign key    = in_request_type[6:0];
  assign ep_ok  = {1'b0, in_index_word[3:0]} < 5'(NUM_ENDPOINTS);

  always_comb begin
    ok_req   = 1'b0;
    op       = OP_NONE;
    src      = SRC_STATUS;
    tl       = '0;
    desc_len = '0;
    desc_src = SRC_STATUS;
    case (in_value_word[15:8])
      DESC_DEVICE: begin
        desc_src = SRC_DEVICE;
        desc_len = {8'd0, dev_len_r};
      end
      DESC_CONFIG: begin
        desc_src = SRC_CONFIG;
        desc_len = cfg_len_r;
      end
      DESC_STRING: begin
        desc_src = SRC_STRING;
        desc_len = {8'd0, in_string_len};
      end
      default: ;
    endcase
    if (key == RT_VENDOR_DEVICE) begin
      if (in_request_code == vendor_r && in_index_word == COMPAT_INDEX) begin
        ok_req = 1'b1;
        src    = SRC_COMPAT;
        tl     = {8'd0, compat_len_r};
      end
    end else if (key == RT_STD_DEVICE) begin
      case (in_request_code)
        REQ_GET_STATUS: begin
          ok_req = 1'b1;
          tl     = 16'd2;
        end
        REQ_CLEAR_FEATURE: begin
          ok_req = (in_value_word[7:0] == FEAT_REMOTE_WAKEUP);
          op     = OP_CLR_WAKE;
        end
        REQ_SET_FEATURE: begin
          ok_req = (in_value_word[7:0] == FEAT_REMOTE_WAKEUP);
          op     = OP_SET_WAKE;
        end
        REQ_SET_ADDRESS: begin
          ok_req = 1'b1;
          op     = OP_SET_ADDR;
        end
        REQ_GET_DESCRIPTOR: begin
          ok_req = (desc_len != '0);
          src    = desc_src;
          tl     = desc_len;
        end
        REQ_GET_CONFIG: begin
          ok_req = 1'b1;
          src    = SRC_CONFIG_BYTE;
          tl     = 16'd1;
        end
        REQ_SET_CONFIG: begin
          ok_req = 1'b1;
          op     = OP_SET_CFG;
        end
        default: ;
      endcase
    end else if (key == RT_STD_IFACE) begin
      if (in_request_code == REQ_GET_STATUS) begin
        ok_req = 1'b1;
        src    = SRC_ZERO;
        tl     = 16'd2;
      end
    end else if (key == RT_STD_EP) begin
      case (in_request_code)
        REQ_SYNCH_FRAME: begin
          ok_req = 1'b1;
          src    = SRC_ZERO;
          tl     = 16'd2;
        end
        REQ_GET_STATUS: begin
          ok_req = 1'b1;
          op     = OP_EP_STATUS;
          src    = SRC_ZERO;
          tl     = 16'd2;
        end
        REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
          ok_req = (in_value_word == '0);
          op     = OP_EP_FEATURE;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    min_len      = (in_length_word < tl) ? in_length_word : tl;
    dec          = '0;
    dec.op       = op;
    dec.tl       = tl;
    dec.rl       = in_length_word;
    dec.val      = in_value_word[7:0];
    dec.ep_num   = in_index_word[3:0];
    dec.ep_in    = in_index_word[7];
    dec.ep_ok    = ep_ok;
    dec.ep_set   = (in_request_code == REQ_SET_FEATURE);
    dec.ep_apply = ep_ok && (in_index_word[3:0] != 4'd0);
    dec.action   = ACT_NONE;
    dec.phase    = PH_SETUP;
    dec.src      = SRC_STATUS;
    dec.chunk    = '0;
    case (in_command)
      CMD_SETUP:  dec.kind = (in_setup_ok && ok_req) ? K_SETUP : K_ERROR;
      CMD_OUT:    dec.kind = K_OUT;
      CMD_IN:     dec.kind = K_IN;
      default:    dec.kind = K_BUS_RESET;
    endcase
    if (in_request_type[7]) begin
      if (tl != '0) begin
        dec.action = ACT_DATA;
        dec.phase  = PH_TX;
        dec.src    = src;
        dec.chunk  = (min_len > {9'd0, mps}) ? mps : min_len[6:0];
      end else begin
        dec.phase  = PH_STS;
      end
    end else if (tl != '0) begin
      dec.phase  = PH_RX;
    end else begin
      dec.action = ACT_ZLP;
      dec.phase  = PH_SEND_STS;
    end
  end

endmodule

`default_nettype wire

// ===== design/uep0_rem.sv =====
// Bit-serial remainder unit: transfer length modulo the endpoint zero packet size.
// One quotient bit per cycle; uses uep0_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uep0_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  uep0_pkg::rem_req_t req,
  input  logic               restart,
  input  logic [6:0]         divisor,
  output uep0_pkg::rem_sts_t sts
);

  import uep0_pkg::*;

  localparam int CntW = $clog2(LenW + 1);

  logic [LenW-1:0] val_r;
  logic [LenW-1:0] dvd_r;
  logic [6:0]      rem_r;
  logic [CntW-1:0] cnt_r;
  logic [6:0]      trial;

  assign trial    = {rem_r[5:0], dvd_r[LenW-1]};
  assign sts.busy = (cnt_r != '0);
  assign sts.zero = (rem_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      val_r <= '0;
      dvd_r <= '0;
      rem_r <= '0;
    end else if (req.start) begin
      cnt_r <= CntW'(LenW);
      val_r <= req.value;
      dvd_r <= req.value;
      rem_r <= '0;
    end else if (restart) begin
      cnt_r <= CntW'(LenW);
      dvd_r <= val_r;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      dvd_r <= {dvd_r[LenW-2:0], 1'b0};
      rem_r <= (trial >= divisor) ? trial - divisor : trial;
    end
  end

endmodule

`default_nettype wire

// ===== design/uep0_back.sv =====
// Back end: endpoint zero phase, device state and halt bits, one event per cycle
// unless results are full or an IN waits on uep0_rem. Uses uep0_pkg and the status of uep0_rem.
`timescale 1ns / 1ps
`default_nettype none

module uep0_back #(
  parameter int NUM_ENDPOINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  uep0_pkg::dec_t     dec,
  input  logic               dec_valid,
  output logic               dec_pop,
  input  logic               res_full,
  output logic               res_push,
  output uep0_pkg::res_t     res,
  output uep0_pkg::rem_req_t rem_req,
  input  uep0_pkg::rem_sts_t rem_sts
);

  import uep0_pkg::*;

  localparam int EpW = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;

  phase_t                   phase_r, phase_nxt;
  logic [LenW-1:0]          rl_r, rl_nxt;
  logic [LenW-1:0]          tl_r, tl_nxt;
  logic                     wake_r, wake_nxt;
  logic [7:0]               cfg_r, cfg_nxt;
  logic [1:0]               mode_r, mode_nxt;
  logic [6:0]               addr_r, addr_nxt;
  logic [NUM_ENDPOINTS-1:0] halt_out_r, halt_out_nxt;
  logic [NUM_ENDPOINTS-1:0] halt_in_r, halt_in_nxt;
  logic [EpW-1:0]           ep_idx;
  logic                     stall;
  logic                     fire;

  assign ep_idx   = dec.ep_num[EpW-1:0];
  assign stall    = (dec.kind == K_IN) && (phase_r == PH_TX) && rem_sts.busy;
  assign fire     = dec_valid && !res_full && !stall;
  assign dec_pop  = fire;
  assign res_push = fire;

  always_comb begin
    phase_nxt     = phase_r;
    rl_nxt        = rl_r;
    tl_nxt        = tl_r;
    wake_nxt      = wake_r;
    cfg_nxt       = cfg_r;
    mode_nxt      = mode_r;
    addr_nxt      = addr_r;
    halt_out_nxt  = halt_out_r;
    halt_in_nxt   = halt_in_r;
    rem_req.start = 1'b0;
    rem_req.value = dec.tl;
    res           = '0;
    case (dec.kind)
      K_SETUP: begin
        halt_out_nxt[0] = 1'b0;
        halt_in_nxt[0]  = 1'b0;
        phase_nxt       = dec.phase;
        rl_nxt          = dec.rl;
        tl_nxt          = dec.tl;
        res.action      = dec.action;
        res.src         = dec.src;
        res.chunk       = dec.chunk;
        rem_req.start   = fire;
        case (dec.op)
          OP_CLR_WAKE: wake_nxt = 1'b0;
          OP_SET_WAKE: wake_nxt = 1'b1;
          OP_SET_ADDR: begin
            addr_nxt = dec.val[6:0];
            res.aw   = 1'b1;
          end
          OP_SET_CFG: begin
            if (cfg_r != dec.val) begin
              cfg_nxt      = dec.val;
              mode_nxt     = (dec.val == 8'd0) ? MODE_SELECTED : MODE_ACTIVE;
              halt_out_nxt = '0;
              halt_in_nxt  = '0;
              res.cev      = 1'b1;
            end
          end
          OP_EP_STATUS: begin
            if (dec.action == ACT_DATA && dec.ep_ok &&
                (dec.ep_in ? halt_in_nxt[ep_idx] : halt_out_nxt[ep_idx])) begin
              res.src = SRC_HALTED;
            end
          end
          OP_EP_FEATURE: begin
            if (dec.ep_apply) begin
              if (dec.ep_in) begin
                halt_in_nxt[ep_idx] = dec.ep_set;
              end else begin
                halt_out_nxt[ep_idx] = dec.ep_set;
              end
            end
          end
          default: ;
        endcase
      end
      K_OUT: begin
        if (phase_r == PH_RX) begin
          phase_nxt  = PH_SEND_STS;
          res.action = ACT_ZLP;
        end else if (phase_r == PH_STS) begin
          phase_nxt  = PH_SETUP;
        end else begin
          halt_out_nxt[0] = 1'b1;
          halt_in_nxt[0]  = 1'b1;
          phase_nxt       = PH_ERROR;
          res.action      = ACT_STALL;
        end
      end
      K_IN: begin
        if (phase_r == PH_TX) begin
          if (tl_r < rl_r && rem_sts.zero) begin
            phase_nxt  = PH_TX0;
            res.action = ACT_ZLP;
          end else begin
            phase_nxt  = PH_STS;
          end
        end else if (phase_r == PH_TX0) begin
          phase_nxt = PH_STS;
        end else if (phase_r == PH_SEND_STS) begin
          phase_nxt = PH_SETUP;
        end else begin
          halt_out_nxt[0] = 1'b1;
          halt_in_nxt[0]  = 1'b1;
          phase_nxt       = PH_ERROR;
          res.action      = ACT_STALL;
        end
      end
      K_BUS_RESET: begin
        addr_nxt     = '0;
        cfg_nxt      = '0;
        mode_nxt     = MODE_DEFAULT;
        wake_nxt     = 1'b0;
        phase_nxt    = PH_SETUP;
        halt_out_nxt = '0;
        halt_in_nxt  = '0;
        res.aw       = 1'b1;
        res.rst      = 1'b1;
      end
      default: begin
        halt_out_nxt[0] = 1'b1;
        halt_in_nxt[0]  = 1'b1;
        phase_nxt       = PH_ERROR;
        res.action      = ACT_STALL;
      end
    endcase
    res.addr  = addr_nxt;
    res.phase = phase_code(phase_nxt);
    res.mode  = mode_nxt;
    res.cfg   = cfg_nxt;
    res.wake  = wake_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SETUP;
      rl_r       <= '0;
      tl_r       <= '0;
      wake_r     <= 1'b0;
      cfg_r      <= '0;
      mode_r     <= MODE_DEFAULT;
      addr_r     <= '0;
      halt_out_r <= '0;
      halt_in_r  <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      rl_r       <= rl_nxt;
      tl_r       <= tl_nxt;
      wake_r     <= wake_nxt;
      cfg_r      <= cfg_nxt;
      mode_r     <= mode_nxt;
      addr_r     <= addr_nxt;
      halt_out_r <= halt_out_nxt;
      halt_in_r  <= halt_in_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/uep0_checker.sv =====
// Port-level checks for the endpoint zero control handler, bound to the top level.
// Uses uep0_pkg codes.
`timescale 1ns / 1ps
`default_nettype none

module uep0_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [1:0] out_action,
  input logic [2:0] out_data_source,
  input logic [6:0] out_chunk_len,
  input logic       out_address_write,
  input logic [6:0] out_device_address,
  input logic [2:0] out_ep0_phase,
  input logic [7:0] out_configuration,
  input logic       out_reset_event
);

  import uep0_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_stall_error: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_action == ACT_STALL) == (out_ep0_phase == PHC_ERROR)))
    else $error("stall action and error phase disagree");

  a_bus_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_reset_event) |-> (out_address_write && out_device_address == 7'd0 &&
      out_ep0_phase == PHC_SETUP && out_configuration == 8'd0 && out_action == ACT_NONE))
    else $error("bus reset result does not show reset state");

  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_action != ACT_DATA) |->
      (out_data_source == SRC_STATUS && out_chunk_len == 7'd0))
    else $error("source or chunk length set without a data request");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_action) &&
      $stable(out_ep0_phase) && $stable(out_chunk_len)))
    else $error("waiting result changed");

endmodule

bind usb_ep0_control_handler_core uep0_checker u_uep0_checker (.*);

`default_nettype wire

// ===== bench/tb_usb_ep0_control_handler_core.sv =====
// Self-checking testbench for usb_ep0_control_handler_core.
// Directed rows and random transfers are checked against a row's expected result or an
// in-bench predictor of the endpoint zero state machine; depends on uep0_pkg and the RTL.
`timescale 1ns / 1ps

module tb_usb_ep0_control_handler_core;
  import uep0_pkg::*;

  localparam int NUM_EP = 16;
  localparam logic DIR_IN = 1'b1;
  localparam logic DIR_OUT = 1'b0;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        ok;
    logic [7:0]  rtype;
    logic [7:0]  rcode;
    logic [15:0] wvalue;
    logic [15:0] windex;
    logic [15:0] wlength;
    logic [7:0]  slen;
  } ep0_event_t;

  typedef struct {
    ep0_event_t ev;
    bit         has_want;
    res_t       want;
  } ep0_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_push;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_action;
  logic [2:0]  out_data_source;
  logic [6:0]  out_chunk_len;
  logic        out_address_write;
  logic [6:0]  out_device_address;
  logic [2:0]  out_ep0_phase;
  logic [1:0]  out_device_state;
  logic        out_config_event;
  logic [7:0]  out_configuration;
  logic        out_remote_wakeup;
  logic        out_reset_event;

  ep0_event_t drv_ev;
  bit         row_has_want;
  res_t       row_want;
  res_t       pending_results[$];
  ep0_row_t   directed_rows[$];
  int         mismatch_count;
  int         burst_left;
  bit         rx_hold_req;
  int         hold_left;
  int         pop_mode;
  int         pop_mode_left;

  logic [7:0]  reg_dev_desc_len;
  logic [15:0] reg_config_desc_len;
  logic [6:0]  reg_max_packet;
  logic [7:0]  reg_compat_len;
  logic [7:0]  reg_vendor_code;

  logic [2:0]  ph_state;
  logic [15:0] req_len;
  logic [15:0] xfer_len;
  logic        wake_bit;
  logic [7:0]  cfg_value;
  logic [1:0]  dev_mode;
  logic [6:0]  dev_addr;
  logic [31:0] ep_halt;

  usb_ep0_control_handler_core #(
    .NUM_ENDPOINTS(NUM_EP)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_command        (drv_ev.cmd),
    .in_setup_ok       (drv_ev.ok),
    .in_request_type   (drv_ev.rtype),
    .in_request_code   (drv_ev.rcode),
    .in_value_word     (drv_ev.wvalue),
    .in_index_word     (drv_ev.windex),
    .in_length_word    (drv_ev.wlength),
    .in_string_len     (drv_ev.slen),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_action        (out_action),
    .out_data_source   (out_data_source),
    .out_chunk_len     (out_chunk_len),
    .out_address_write (out_address_write),
    .out_device_address(out_device_address),
    .out_ep0_phase     (out_ep0_phase),
    .out_device_state  (out_device_state),
    .out_config_event  (out_config_event),
    .out_configuration (out_configuration),
    .out_remote_wakeup (out_remote_wakeup),
    .out_reset_event   (out_reset_event)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd4_000_000);
    $display("tb_usb_ep0_control_handler_core: FAIL");
    $finish;
  end

  function automatic ep0_event_t make_event(input logic [1:0] cmd, input logic ok,
                                            input logic [7:0] rtype, input logic [7:0] rcode,
                                            input logic [15:0] wvalue, input logic [15:0] windex,
                                            input logic [15:0] wlength, input logic [7:0] slen);
    ep0_event_t ev;
    ev.cmd = cmd;
    ev.ok = ok;
    ev.rtype = rtype;
    ev.rcode = rcode;
    ev.wvalue = wvalue;
    ev.windex = windex;
    ev.wlength = wlength;
    ev.slen = slen;
    return ev;
  endfunction

  function automatic res_t pack_result(input logic [1:0] action, input logic [2:0] src,
                                       input logic [6:0] chunk, input logic aw,
                                       input logic [6:0] addr, input logic [2:0] phase,
                                       input logic [1:0] mode, input logic cev,
                                       input logic [7:0] cfg, input logic wake,
                                       input logic rst);
    res_t r;
    r.action = action;
    r.src = src;
    r.chunk = chunk;
    r.aw = aw;
    r.addr = addr;
    r.phase = phase;
    r.mode = mode;
    r.cev = cev;
    r.cfg = cfg;
    r.wake = wake;
    r.rst = rst;
    return r;
  endfunction

  function automatic logic [6:0] ep0_mps();
    if (reg_max_packet < MPS_MIN) return MPS_MIN;
    if (reg_max_packet > MPS_MAX) return MPS_MAX;
    return reg_max_packet;
  endfunction

  // Advances the endpoint zero state by one event and returns the result it reports.
  task automatic ep0_control_step(input ep0_event_t ev, output res_t r);
    logic [6:0]  key;
    logic [4:0]  slot;
    logic        slot_ok;
    logic        ok;
    logic        err;
    logic [2:0]  src;
    logic [15:0] len;
    logic [15:0] chunk;
    r = '0;
    key = ev.rtype[6:0];
    slot = {ev.windex[7], ev.windex[3:0]};
    slot_ok = ev.windex[3:0] < NUM_EP;
    ok = 1'b0;
    err = 1'b0;
    src = SRC_STATUS;
    len = '0;
    case (ev.cmd)
      CMD_SETUP: begin
        ep_halt[0] = 1'b0;
        ep_halt[16] = 1'b0;
        if (ev.ok) begin
          req_len = ev.wlength;
          if (key == RT_VENDOR_DEVICE) begin
            if (ev.rcode == reg_vendor_code && ev.windex == COMPAT_INDEX) begin
              ok = 1'b1;
              src = SRC_COMPAT;
              len = {8'd0, reg_compat_len};
            end
          end else if (key == RT_STD_DEVICE) begin
            case (ev.rcode)
              REQ_GET_STATUS: begin
                ok = 1'b1;
                len = 16'd2;
              end
              REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                if (ev.wvalue[7:0] == FEAT_REMOTE_WAKEUP) begin
                  ok = 1'b1;
                  wake_bit = ev.rcode == REQ_SET_FEATURE;
                end
              end
              REQ_SET_ADDRESS: begin
                ok = 1'b1;
                dev_addr = ev.wvalue[6:0];
                r.aw = 1'b1;
              end
              REQ_GET_DESCRIPTOR: begin
                case (ev.wvalue[15:8])
                  DESC_DEVICE: begin
                    src = SRC_DEVICE;
                    len = {8'd0, reg_dev_desc_len};
                  end
                  DESC_CONFIG: begin
                    src = SRC_CONFIG;
                    len = reg_config_desc_len;
                  end
                  DESC_STRING: begin
                    src = SRC_STRING;
                    len = {8'd0, ev.slen};
                  end
                  default: ;
                endcase
                ok = len != 16'd0;
              end
              REQ_GET_CONFIG: begin
                ok = 1'b1;
                src = SRC_CONFIG_BYTE;
                len = 16'd1;
              end
              REQ_SET_CONFIG: begin
                ok = 1'b1;
                if (cfg_value != ev.wvalue[7:0]) begin
                  cfg_value = ev.wvalue[7:0];
                  dev_mode = (cfg_value == 8'd0) ? MODE_SELECTED : MODE_ACTIVE;
                  ep_halt = '0;
                  r.cev = 1'b1;
                end
              end
              default: ;
            endcase
          end else if (key == RT_STD_IFACE) begin
            if (ev.rcode == REQ_GET_STATUS) begin
              ok = 1'b1;
              src = SRC_ZERO;
              len = 16'd2;
            end
          end else if (key == RT_STD_EP) begin
            case (ev.rcode)
              REQ_SYNCH_FRAME: begin
                ok = 1'b1;
                src = SRC_ZERO;
                len = 16'd2;
              end
              REQ_GET_STATUS: begin
                ok = 1'b1;
                src = (slot_ok && ep_halt[slot]) ? SRC_HALTED : SRC_ZERO;
                len = 16'd2;
              end
              REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                if (ev.wvalue == 16'd0) begin
                  ok = 1'b1;
                  if (ev.windex[3:0] != 4'd0 && slot_ok) begin
                    ep_halt[slot] = ev.rcode == REQ_SET_FEATURE;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        if (!ok) begin
          err = 1'b1;
        end else begin
          xfer_len = len;
          if (ev.rtype[7]) begin
            if (xfer_len != 16'd0) begin
              chunk = (req_len < xfer_len) ? req_len : xfer_len;
              if (chunk > {9'd0, ep0_mps()}) chunk = {9'd0, ep0_mps()};
              r.action = ACT_DATA;
              r.src = src;
              r.chunk = chunk[6:0];
              ph_state = PHC_TX;
            end else begin
              ph_state = PHC_STS;
            end
          end else if (xfer_len != 16'd0) begin
            ph_state = PHC_RX;
          end else begin
            r.action = ACT_ZLP;
            ph_state = PHC_SEND_STS;
          end
        end
      end
      CMD_OUT: begin
        if (ph_state == PHC_RX) begin
          ph_state = PHC_SEND_STS;
          r.action = ACT_ZLP;
        end else if (ph_state == PHC_STS) begin
          ph_state = PHC_SETUP;
        end else begin
          err = 1'b1;
        end
      end
      CMD_IN: begin
        if (ph_state == PHC_TX) begin
          if (xfer_len < req_len && (xfer_len % {9'd0, ep0_mps()}) == 16'd0) begin
            r.action = ACT_ZLP;
            ph_state = PHC_TX0;
          end else begin
            ph_state = PHC_STS;
          end
        end else if (ph_state == PHC_TX0) begin
          ph_state = PHC_STS;
        end else if (ph_state == PHC_SEND_STS) begin
          ph_state = PHC_SETUP;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        dev_addr = '0;
        cfg_value = '0;
        dev_mode = MODE_DEFAULT;
        wake_bit = 1'b0;
        ph_state = PHC_SETUP;
        ep_halt = '0;
        r.aw = 1'b1;
        r.rst = 1'b1;
      end
    endcase
    if (err) begin
      ep_halt[0] = 1'b1;
      ep_halt[16] = 1'b1;
      ph_state = PHC_ERROR;
      r.action = ACT_STALL;
    end
    r.addr = dev_addr;
    r.phase = ph_state;
    r.mode = dev_mode;
    r.cfg = cfg_value;
    r.wake = wake_bit;
  endtask

  always @(posedge clk) begin
    res_t pred;
    res_t got;
    res_t want;
    if (rst_n && in_push && !in_full) begin
      ep0_control_step(drv_ev, pred);
      pending_results.push_back(row_has_want ? row_want : pred);
    end
    if (rst_n && out_pop && !out_empty) begin
      got = pack_result(out_action, out_data_source, out_chunk_len, out_address_write,
                        out_device_address, out_ep0_phase, out_device_state,
                        out_config_event, out_configuration, out_remote_wakeup,
                        out_reset_event);
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) $display("Unexpected result at %0t: %h", $realtime, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.action !== want.action || got.src !== want.src || got.chunk !== want.chunk ||
            got.aw !== want.aw || got.addr !== want.addr || got.phase !== want.phase ||
            got.mode !== want.mode || got.cev !== want.cev || got.cfg !== want.cfg ||
            got.wake !== want.wake || got.rst !== want.rst) begin
          if (mismatch_count < 10) begin
            $display("Mismatch at %0t: expected act=%0d src=%0d len=%0d aw=%0d addr=%0d ph=%0d",
                     $realtime, want.action, want.src, want.chunk, want.aw, want.addr,
                     want.phase);
            $display("  mode=%0d cev=%0d cfg=%0d wake=%0d rst=%0d", want.mode, want.cev,
                     want.cfg, want.wake, want.rst);
            $display("  actual act=%0d src=%0d len=%0d aw=%0d addr=%0d ph=%0d", got.action,
                     got.src, got.chunk, got.aw, got.addr, got.phase);
            $display("  mode=%0d cev=%0d cfg=%0d wake=%0d rst=%0d", got.mode, got.cev,
                     got.cfg, got.wake, got.rst);
          end
          mismatch_count++;
        end
      end
    end
  end

  // The result side alternates between pop patterns and honors one long hold request.
  initial begin
    out_pop = 1'b0;
    hold_left = 0;
    pop_mode_left = 0;
    pop_mode = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (pop_mode_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        pop_mode_left = $urandom_range(16, 96);
      end
      pop_mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_pop = 1'b0;
      end else begin
        case (pop_mode)
          0: out_pop = 1'b1;
          1: out_pop = $urandom_range(0, 3) != 0;
          2: out_pop = $urandom_range(0, 1) != 0;
          default: out_pop = $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  task automatic offer(input ep0_event_t ev, input bit has_want, input res_t want);
    if (burst_left == 0) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    drv_ev = ev;
    row_has_want = has_want;
    row_want = want;
    in_push = 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DEVICE_DESC_LEN:    reg_dev_desc_len = data[7:0];
      CFG_CONFIG_DESC_LEN:    reg_config_desc_len = data;
      CFG_MAX_PACKET_SIZE0:   reg_max_packet = data[6:0];
      CFG_COMPAT_ID_LEN:      reg_compat_len = data[7:0];
      CFG_COMPAT_VENDOR_CODE: reg_vendor_code = data[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic add_row(input ep0_event_t ev, input bit has_want, input res_t want);
    ep0_row_t row;
    row.ev = ev;
    row.has_want = has_want;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Mostly well-formed transfers that follow the current phase, with some noise.
  task automatic next_event(output ep0_event_t ev);
    logic [15:0] ep_index;
    ev = make_event(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 8'($urandom));
    if ($urandom_range(0, 11) != 0) begin
      case (ph_state)
        PHC_TX, PHC_TX0, PHC_SEND_STS: ev.cmd = CMD_IN;
        PHC_STS, PHC_RX:               ev.cmd = CMD_OUT;
        default:                       ev.cmd = CMD_SETUP;
      endcase
    end
    if (ev.cmd == CMD_SETUP) begin
      ev.ok = $urandom_range(0, 24) != 0;
      case ($urandom_range(0, 4))
        0: ev.wlength = 16'd0;
        1: ev.wlength = 16'($urandom);
        2: ev.wlength = 16'(ep0_mps() * $urandom_range(1, 4));
        default: ev.wlength = 16'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 3))
        0: ev.slen = 8'd0;
        1: ev.slen = 8'(ep0_mps() * $urandom_range(1, 3));
        default: ev.slen = 8'($urandom);
      endcase
      ep_index = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                 {8'($urandom), 1'($urandom), 3'd0, 4'($urandom)};
      case ($urandom_range(0, 13))
        0: begin
          ev.rtype = {DIR_IN, RT_STD_DEVICE};
          ev.rcode = REQ_GET_STATUS;
        end
        1: begin
          ev.rtype = {DIR_OUT, RT_STD_DEVICE};
          ev.rcode = $urandom_range(0, 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
          if ($urandom_range(0, 1)) ev.wvalue = {8'($urandom), FEAT_REMOTE_WAKEUP};
        end
        2: begin
          ev.rtype = {DIR_OUT, RT_STD_DEVICE};
          ev.rcode = REQ_SET_ADDRESS;
        end
        3, 4: begin
          ev.rtype = {DIR_IN, RT_STD_DEVICE};
          ev.rcode = REQ_GET_DESCRIPTOR;
          ev.wvalue[15:8] = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
                            8'($urandom_range(DESC_DEVICE, DESC_STRING));
        end
        5: begin
          ev.rtype = {DIR_IN, RT_STD_DEVICE};
          ev.rcode = REQ_GET_CONFIG;
        end
        6: begin
          ev.rtype = {DIR_OUT, RT_STD_DEVICE};
          ev.rcode = REQ_SET_CONFIG;
          if ($urandom_range(0, 3) != 0) ev.wvalue[7:0] = 8'($urandom_range(0, 3));
        end
        7: begin
          ev.rtype = {DIR_IN, RT_STD_IFACE};
          ev.rcode = REQ_GET_STATUS;
        end
        8: begin
          ev.rtype = {DIR_IN, RT_STD_EP};
          ev.rcode = REQ_GET_STATUS;
          ev.windex = ep_index;
        end
        9: begin
          ev.rtype = {DIR_OUT, RT_STD_EP};
          ev.rcode = $urandom_range(0, 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
          ev.windex = ep_index;
          if ($urandom_range(0, 4) != 0) ev.wvalue = 16'd0;
        end
        10: begin
          ev.rtype = {DIR_IN, RT_STD_EP};
          ev.rcode = REQ_SYNCH_FRAME;
        end
        11, 12: begin
          ev.rtype = {DIR_IN, RT_VENDOR_DEVICE};
          if ($urandom_range(0, 3) != 0) ev.rcode = reg_vendor_code;
          if ($urandom_range(0, 3) != 0) ev.windex = COMPAT_INDEX;
        end
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) ev.rtype[7] = ~ev.rtype[7];
    end
  endtask

  initial begin
    ep0_event_t  ev;
    logic [15:0] dd;
    logic [15:0] cd;
    logic [15:0] mp;
    logic [15:0] cl;
    logic [15:0] vc;
    drv_ev = '0;
    row_has_want = 1'b0;
    row_want = '0;
    in_push = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    rx_hold_req = 1'b0;
    mismatch_count = 0;
    burst_left = 0;
    reg_dev_desc_len = 8'd18;
    reg_config_desc_len = 16'd32;
    reg_max_packet = 7'd64;
    reg_compat_len = 8'd40;
    reg_vendor_code = 8'd32;
    ph_state = PHC_SETUP;
    req_len = '0;
    xfer_len = '0;
    wake_bit = 1'b0;
    cfg_value = '0;
    dev_mode = MODE_DEFAULT;
    dev_addr = '0;
    ep_halt = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    add_row(make_event(CMD_BUS_RESET, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF),
            1'b1, pack_result(ACT_NONE, SRC_STATUS, 7'd0, 1'b1, 7'd0, PHC_SETUP, MODE_DEFAULT,
                              1'b0, 8'd0, 1'b0, 1'b1));
    add_row(make_event(CMD_SETUP, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF),
            1'b1, pack_result(ACT_STALL, SRC_STATUS, 7'd0, 1'b0, 7'd0, PHC_ERROR, MODE_DEFAULT,
                              1'b0, 8'd0, 1'b0, 1'b0));
    add_row(make_event(CMD_OUT, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, pack_result(ACT_STALL, SRC_STATUS, 7'd0, 1'b0, 7'd0, PHC_ERROR, MODE_DEFAULT,
                              1'b0, 8'd0, 1'b0, 1'b0));
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_IN, RT_STD_DEVICE}, REQ_GET_DESCRIPTOR,
                       {DESC_DEVICE, 8'h00}, 16'h0000, 16'hFFFF, 8'h00),
            1'b1, pack_result(ACT_DATA, SRC_DEVICE, 7'd18, 1'b0, 7'd0, PHC_TX, MODE_DEFAULT,
                              1'b0, 8'd0, 1'b0, 1'b0));
    add_row(make_event(CMD_IN, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, pack_result(ACT_NONE, SRC_STATUS, 7'd0, 1'b0, 7'd0, PHC_STS, MODE_DEFAULT,
                              1'b0, 8'd0, 1'b0, 1'b0));
    add_row(make_event(CMD_OUT, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, pack_result(ACT_NONE, SRC_STATUS, 7'd0, 1'b0, 7'd0, PHC_SETUP, MODE_DEFAULT,
                              1'b0, 8'd0, 1'b0, 1'b0));
    add_row(make_event(CMD_IN, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, pack_result(ACT_STALL, SRC_STATUS, 7'd0, 1'b0, 7'd0, PHC_ERROR, MODE_DEFAULT,
                              1'b0, 8'd0, 1'b0, 1'b0));
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_OUT, RT_STD_DEVICE}, REQ_SET_ADDRESS, 16'hFFFF,
                       16'h0000, 16'h0000, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_OUT, RT_STD_DEVICE}, REQ_SET_CONFIG, 16'h00FF,
                       16'h0000, 16'h0000, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_IN, RT_STD_DEVICE}, REQ_GET_CONFIG, 16'h0000,
                       16'h0000, 16'h0001, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_IN, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b0, '0);
    add_row(make_event(CMD_OUT, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_OUT, RT_STD_DEVICE}, REQ_SET_FEATURE,
                       {8'h00, FEAT_REMOTE_WAKEUP}, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_OUT, RT_STD_DEVICE}, REQ_CLEAR_FEATURE,
                       {8'h00, FEAT_REMOTE_WAKEUP}, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_OUT, RT_STD_EP}, REQ_SET_FEATURE, 16'h0000,
                       16'h0081, 16'h0000, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_IN, RT_STD_EP}, REQ_GET_STATUS, 16'h0000,
                       16'h0081, 16'h0002, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_BUS_RESET, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_IN, RT_VENDOR_DEVICE}, 8'd32, 16'h0000,
                       COMPAT_INDEX, 16'h0040, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_IN, RT_STD_DEVICE}, REQ_GET_DESCRIPTOR,
                       {DESC_CONFIG, 8'h00}, 16'h0000, 16'h0080, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_OUT, RT_STD_DEVICE}, REQ_GET_STATUS, 16'h0000,
                       16'h0000, 16'h0002, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_OUT, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b0, '0);
    add_row(make_event(CMD_IN, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_IN, RT_STD_DEVICE}, REQ_GET_DESCRIPTOR,
                       {DESC_STRING, 8'h00}, 16'h0000, 16'h00FF, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_IN, RT_STD_IFACE}, REQ_GET_STATUS, 16'h0000,
                       16'h0000, 16'h0002, 8'h00), 1'b0, '0);
    add_row(make_event(CMD_SETUP, 1'b1, {DIR_IN, RT_STD_DEVICE}, 8'hFF, 16'h0000, 16'h0000,
                       16'h0002, 8'h00), 1'b0, '0);

    foreach (directed_rows[i]) offer(directed_rows[i].ev, directed_rows[i].has_want,
                                     directed_rows[i].want);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p > 0) begin
        wait_all_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        case (p)
          1: begin
            dd = 16'd255; cd = 16'hFFFF; mp = 16'd64; cl = 16'd255; vc = 16'd255;
          end
          2: begin
            dd = 16'd0; cd = 16'd0; mp = 16'd8; cl = 16'd0; vc = 16'd0;
          end
          3: begin
            dd = 16'd16; cd = 16'd64; mp = 16'd0; cl = 16'd24; vc = 16'($urandom_range(0, 255));
          end
          4: begin
            dd = 16'd64; cd = 16'd128; mp = 16'd127; cl = 16'd128;
            vc = 16'($urandom_range(0, 255));
          end
          5: begin
            dd = 16'(8 * $urandom_range(1, 8)); cd = 16'($urandom_range(1, 600)); mp = 16'd32;
            cl = 16'($urandom_range(0, 255)); vc = 16'($urandom_range(0, 255));
          end
          default: begin
            dd = 16'($urandom); cd = 16'($urandom); mp = 16'($urandom);
            cl = 16'($urandom); vc = 16'($urandom);
          end
        endcase
        write_reg(CFG_DEVICE_DESC_LEN, dd);
        write_reg(CFG_CONFIG_DESC_LEN, cd);
        write_reg(CFG_MAX_PACKET_SIZE0, mp);
        write_reg(CFG_COMPAT_ID_LEN, cl);
        write_reg(CFG_COMPAT_VENDOR_CODE, vc);
        cfg_valid = 1'b0;
      end
      if (p == 2) rx_hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) wait_all_results();
        next_event(ev);
        offer(ev, 1'b0, '0);
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_usb_ep0_control_handler_core: PASS");
    end else begin
      $display("tb_usb_ep0_control_handler_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/uep0_pkg.sv
design/uep0_fifo.sv
design/uep0_front.sv
design/uep0_rem.sv
design/uep0_back.sv
design/usb_ep0_control_handler_core.sv
design/uep0_checker.sv
bench/tb_usb_ep0_control_handler_core.sv
